### hdl/assert_macros.svh
// Assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### hdl/msm_pkg.sv
package msm_pkg;

   localparam int NUM_WORDS = 8;
   localparam int WORD_W    = 32;
   localparam int WIDX_W    = 3;
   localparam int PWORDS    = 2 * NUM_WORDS;
   localparam int PIDX_W    = 4;
   // column sum of NUM_WORDS products plus incoming carry
   localparam int ACC_W     = 2 * WORD_W + $clog2(NUM_WORDS) + 2;

   typedef struct packed {
      logic [WIDX_W-1:0] word_index;
      logic [WORD_W-1:0] a_word;
      logic [WORD_W-1:0] b_word;
      logic              last_load;
   } req_type;

   typedef struct packed {
      logic [PIDX_W-1:0] product_index;
      logic [WORD_W-1:0] product_word;
      logic              last_word;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_FLUSH,
      ST_WAIT,
      ST_EMIT
   } state_type;

   // one step of the column scan
   typedef struct packed {
      logic              valid;
      logic              flush;
      logic              col_end;
      logic [WIDX_W-1:0] a_idx;
      logic [WIDX_W-1:0] b_idx;
      logic [PIDX_W-1:0] wpos;
   } tok_type;

   // product word write
   typedef struct packed {
      logic              valid;
      logic              last;
      logic [PIDX_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } pwr_type;

   // product word read for output
   typedef struct packed {
      logic              valid;
      logic              last;
      logic [PIDX_W-1:0] addr;
   } prd_type;

endpackage

### hdl/msm_seq.sv
`include "assert_macros.svh"

module msm_seq (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            last_load,
   input  logic            mac_done,
   output logic            busy,
   output msm_pkg::tok_type tok,
   output msm_pkg::prd_type prd
);
   import msm_pkg::*;

   state_type         state_ff, state_in;
   logic [PIDX_W-1:0] col_ff, col_in;
   logic [WIDX_W-1:0] i_ff, i_in;
   logic [PIDX_W-1:0] k_ff, k_in;

   logic [PIDX_W-1:0] col_dec;
   logic [WIDX_W-1:0] lo;
   logic [WIDX_W-1:0] hi_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
         i_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         i_ff     <= i_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      col_dec = col_ff - PIDX_W'(1);
      lo = (col_ff >= PIDX_W'(NUM_WORDS - 1)) ?
           WIDX_W'(col_ff - PIDX_W'(NUM_WORDS - 1)) : '0;
      hi_next = (col_dec >= PIDX_W'(NUM_WORDS - 1)) ?
                WIDX_W'(NUM_WORDS - 1) : WIDX_W'(col_dec);

      state_in = state_ff;
      col_in   = col_ff;
      i_in     = i_ff;
      k_in     = k_ff;
      busy     = (state_ff != ST_IDLE);
      tok      = '0;
      prd      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start && last_load) begin
               col_in   = PIDX_W'(PWORDS - 2);
               i_in     = WIDX_W'(NUM_WORDS - 1);
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            tok.valid   = 1'b1;
            tok.a_idx   = i_ff;
            tok.b_idx   = WIDX_W'(col_ff - PIDX_W'(i_ff));
            tok.col_end = (i_ff == lo);
            tok.wpos    = col_ff + PIDX_W'(1);
            if (tok.col_end) begin
               if (col_ff == '0) begin
                  state_in = ST_FLUSH;
               end else begin
                  col_in = col_dec;
                  i_in   = hi_next;
               end
            end else begin
               i_in = i_ff - WIDX_W'(1);
            end
         end
         ST_FLUSH: begin
            tok.valid   = 1'b1;
            tok.flush   = 1'b1;
            tok.col_end = 1'b1;
            tok.wpos    = '0;
            state_in    = ST_WAIT;
         end
         ST_WAIT: begin
            if (mac_done) begin
               k_in     = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            prd.valid = 1'b1;
            prd.addr  = k_ff;
            prd.last  = (k_ff == PIDX_W'(PWORDS - 1));
            k_in      = k_ff + PIDX_W'(1);
            if (prd.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `ASSERT_NEXT(a_start_mac, clock, reset, start && !busy && last_load, state_ff == ST_MAC)
   `ASSERT_IMPLIES(a_bidx_range, clock, reset, state_ff == ST_MAC,
                   col_ff >= PIDX_W'(i_ff) && (col_ff - PIDX_W'(i_ff)) < PIDX_W'(NUM_WORDS))
   `ASSERT_IMPLIES(a_done_in_wait, clock, reset, mac_done, state_ff == ST_WAIT)
   `ASSERT_NEXT(a_emit_end, clock, reset, prd.valid && prd.last, state_ff == ST_IDLE)

endmodule

### hdl/msm_mac.sv
module msm_mac (
   input  logic             clock,
   input  logic             reset,
   input  logic             load_en,
   input  msm_pkg::req_type req,
   input  msm_pkg::tok_type tok,
   output msm_pkg::pwr_type pwr
);
   import msm_pkg::*;

   logic [WORD_W-1:0] a_store_mem [NUM_WORDS];
   logic [WORD_W-1:0] b_store_mem [NUM_WORDS];

   logic [WORD_W-1:0]   a_rd_ff, b_rd_ff;
   logic [2*WORD_W-1:0] prod_ff;
   tok_type             tok1_ff, tok2_ff;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [ACC_W-1:0]    sum;

   always_ff @(posedge clock) begin
      if (load_en) begin
         a_store_mem[req.word_index] <= req.a_word;
         b_store_mem[req.word_index] <= req.b_word;
      end
      a_rd_ff <= a_store_mem[tok.a_idx];
      b_rd_ff <= b_store_mem[tok.b_idx];
   end

   always_ff @(posedge clock) begin
      if (tok1_ff.flush) begin
         prod_ff <= '0;
      end else begin
         prod_ff <= a_rd_ff * b_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok1_ff <= '0;
         tok2_ff <= '0;
         acc_ff  <= '0;
      end else begin
         tok1_ff <= tok;
         tok2_ff <= tok1_ff;
         acc_ff  <= acc_in;
      end
   end

   always_comb begin
      sum    = acc_ff + ACC_W'(prod_ff);
      acc_in = acc_ff;
      if (tok2_ff.valid) begin
         if (tok2_ff.flush) begin
            acc_in = '0;
         end else if (tok2_ff.col_end) begin
            acc_in = sum >> WORD_W;
         end else begin
            acc_in = sum;
         end
      end
      pwr.valid = tok2_ff.valid && tok2_ff.col_end;
      pwr.last  = tok2_ff.valid && tok2_ff.flush;
      pwr.addr  = tok2_ff.wpos;
      pwr.data  = sum[WORD_W-1:0];
   end

endmodule

### hdl/msm_prod_mem.sv
module msm_prod_mem (
   input  logic             clock,
   input  logic             reset,
   input  msm_pkg::pwr_type pwr,
   input  msm_pkg::prd_type prd,
   output logic             rsp_strobe,
   output msm_pkg::rsp_type rsp_data
);
   import msm_pkg::*;

   logic [WORD_W-1:0] prod_mem [PWORDS];

   logic [WORD_W-1:0] rd_data_ff;
   logic [PIDX_W-1:0] rd_idx_ff;
   logic              rd_last_ff;
   logic              strobe_ff;

   always_ff @(posedge clock) begin
      if (pwr.valid) begin
         prod_mem[pwr.addr] <= pwr.data;
      end
      rd_data_ff <= prod_mem[prd.addr];
      rd_idx_ff  <= prd.addr;
      rd_last_ff <= prd.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= prd.valid;
      end
   end

   assign rsp_strobe             = strobe_ff;
   assign rsp_data.product_index = rd_idx_ff;
   assign rsp_data.product_word  = rd_data_ff;
   assign rsp_data.last_word     = rd_last_ff;

endmodule

### hdl/multiword_schoolbook_multiplier.sv
// Load items one at a time; busy stays low while loading.
// The item with last_load starts the product: all NUM_WORDS^2 partial products on the one
// 32x32 multiplier (one partial product a cycle), then a flush token to drain.
// The 2*NUM_WORDS product words follow on consecutive cycles, one per strobe.
// Synchronous active-high reset idles the sequencer; operand stores keep no reset.
module multiword_schoolbook_multiplier (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  msm_pkg::req_type req_data,
   output logic             rsp_strobe,
   output msm_pkg::rsp_type rsp_data
);
   import msm_pkg::*;

   tok_type tok;
   prd_type prd;
   pwr_type pwr;
   logic    load_en;
   logic    mac_done;

   assign load_en  = start && !busy && (int'(req_data.word_index) < NUM_WORDS);
   assign mac_done = pwr.last;

   msm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .last_load (req_data.last_load),
      .mac_done  (mac_done),
      .busy      (busy),
      .tok       (tok),
      .prd       (prd)
   );

   msm_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .load_en (load_en),
      .req     (req_data),
      .tok     (tok),
      .pwr     (pwr)
   );

   msm_prod_mem u_prod_mem (
      .clock      (clock),
      .reset      (reset),
      .pwr        (pwr),
      .prd        (prd),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
